[rtl/http_request_line_parser_core_defines.svh]
// ============================================================================
// HTTP request-line parser: assertion macros
// Shared macros for the port checker; clocked on aclk.
// ============================================================================
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH

// Checked only out of reset.
`define HRLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/hrlp_pkg.sv]
// ============================================================================
// HTTP request-line parser: package
// Codes, widths, parser state type and token tables.
// ============================================================================
`default_nettype none

package hrlp_pkg;

    localparam int MAX_REQUEST_BYTES = 4095;
    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int URI_W = 12;
    localparam logic [URI_W-1:0] URI_MAX = {URI_W{1'b1}};

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_INC = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // method codes
    localparam logic [2:0] MTH_NONE = 3'd0;
    localparam logic [2:0] MTH_GET  = 3'd1;
    localparam logic [2:0] MTH_HEAD = 3'd2;
    localparam logic [2:0] MTH_POST = 3'd3;
    localparam logic [2:0] MTH_PUT  = 3'd4;

    // version codes
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_1_0  = 2'd1;
    localparam logic [1:0] VER_1_1  = 2'd2;

    // token lengths
    localparam logic [2:0] LEN_GET  = 3'd3;
    localparam logic [2:0] LEN_HEAD = 3'd4;
    localparam logic [2:0] LEN_POST = 3'd4;
    localparam logic [2:0] LEN_PUT  = 3'd3;
    localparam logic [2:0] LEN_VER  = 3'd7;

    // URI start offsets
    localparam logic [2:0] OFS_SHORT = 3'd4;
    localparam logic [2:0] OFS_LONG  = 3'd5;

    typedef enum logic [7:0] {
        PH_FIRST = 8'b0000_0001,
        PH_G     = 8'b0000_0010,
        PH_H     = 8'b0000_0100,
        PH_P     = 8'b0000_1000,
        PH_URI   = 8'b0001_0000,
        PH_VER   = 8'b0010_0000,
        PH_MINOR = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [POS_W-1:0] pos;
        logic [2:0]       progress;
        logic [1:0]       mismatch;
        logic [2:0]       method_code;
        logic [2:0]       uri_start;
        logic [URI_W-1:0] uri_count;
    } hrlp_state_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [2:0]       method;
        logic [1:0]       version;
        logic [2:0]       method_length;
        logic [2:0]       uri_offset;
        logic [URI_W-1:0] uri_length;
    } hrlp_result_t;

    localparam hrlp_state_t STATE_RESET = '{
        phase:       PH_FIRST,
        pos:         '0,
        progress:    '0,
        mismatch:    '0,
        method_code: MTH_NONE,
        uri_start:   '0,
        uri_count:   '0
    };

    function automatic logic is_ws(input logic [7:0] b);
        return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20) || (b == 8'hA0);
    endfunction

    function automatic logic [7:0] tok_get(input logic [2:0] p);
        unique case (p)
            3'd0:    return "E";
            3'd1:    return "T";
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] tok_head(input logic [2:0] p);
        unique case (p)
            3'd0:    return "E";
            3'd1:    return "A";
            3'd2:    return "D";
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] tok_post(input logic [2:0] p);
        unique case (p)
            3'd0:    return "O";
            3'd1:    return "S";
            3'd2:    return "T";
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] tok_put(input logic [2:0] p);
        unique case (p)
            3'd0:    return "U";
            3'd1:    return "T";
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] tok_ver(input logic [2:0] p);
        unique case (p)
            3'd0:    return "H";
            3'd1:    return "T";
            3'd2:    return "T";
            3'd3:    return "P";
            3'd4:    return "/";
            3'd5:    return "1";
            default: return ".";
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/hrlp_step.sv]
// ============================================================================
// HTTP request-line parser: per-byte step
// Next parser state and optional result for one byte.
// ============================================================================
`default_nettype none

module hrlp_step
    import hrlp_pkg::*;
(
    input  hrlp_state_t  cur,
    input  logic [7:0]   data_byte,
    input  logic         last,
    output hrlp_state_t  nxt,
    output hrlp_result_t res
);

    logic [2:0]       p_inc;
    logic [1:0]       mm_n;
    logic             hit;
    logic [1:0]       st;
    logic [1:0]       ver;
    logic [POS_W-1:0] pos_n;
    logic             decided;

    always_comb begin
        nxt     = cur;
        hit     = 1'b0;
        st      = ST_ERR;
        ver     = VER_NONE;
        p_inc   = cur.progress + 3'd1;
        mm_n    = cur.mismatch;
        decided = (cur.phase == PH_DONE);

        unique case (cur.phase)
            PH_FIRST: begin
                nxt.progress = '0;
                nxt.mismatch = '0;
                if (data_byte == "G") begin
                    nxt.phase = PH_G;
                end else if (data_byte == "H") begin
                    nxt.phase = PH_H;
                end else if (data_byte == "P") begin
                    nxt.phase = PH_P;
                end else begin
                    hit = 1'b1;
                end
            end
            PH_G: begin
                if (cur.progress < LEN_GET && data_byte != tok_get(cur.progress))
                    mm_n[0] = 1'b1;
                nxt.mismatch = mm_n;
                nxt.progress = p_inc;
                if (p_inc >= LEN_GET) begin
                    if (mm_n != 2'b00) begin
                        hit = 1'b1;
                    end else begin
                        nxt.method_code = MTH_GET;
                        nxt.uri_start   = OFS_SHORT;
                        nxt.uri_count   = '0;
                        nxt.phase       = PH_URI;
                    end
                end
            end
            PH_H: begin
                if (cur.progress < LEN_HEAD && data_byte != tok_head(cur.progress))
                    mm_n[0] = 1'b1;
                nxt.mismatch = mm_n;
                nxt.progress = p_inc;
                if (p_inc >= LEN_HEAD) begin
                    if (mm_n != 2'b00) begin
                        hit = 1'b1;
                    end else begin
                        nxt.method_code = MTH_HEAD;
                        nxt.uri_start   = OFS_LONG;
                        nxt.uri_count   = '0;
                        nxt.phase       = PH_URI;
                    end
                end
            end
            PH_P: begin
                if (cur.progress < LEN_POST && data_byte != tok_post(cur.progress))
                    mm_n[0] = 1'b1;
                if (cur.progress < LEN_PUT && data_byte != tok_put(cur.progress))
                    mm_n[1] = 1'b1;
                nxt.mismatch = mm_n;
                nxt.progress = p_inc;
                if (p_inc >= LEN_POST) begin
                    if (!mm_n[0]) begin
                        nxt.method_code = MTH_POST;
                        nxt.uri_start   = OFS_LONG;
                        nxt.uri_count   = '0;
                        nxt.phase       = PH_URI;
                    end else if (!mm_n[1]) begin
                        // fourth byte already belongs to the URI
                        nxt.method_code = MTH_PUT;
                        nxt.uri_start   = OFS_SHORT;
                        if (is_ws(data_byte)) begin
                            nxt.uri_count = '0;
                            nxt.phase     = PH_VER;
                            nxt.progress  = '0;
                            nxt.mismatch  = '0;
                        end else begin
                            nxt.uri_count = URI_W'(1);
                            nxt.phase     = PH_URI;
                        end
                    end else begin
                        hit = 1'b1;
                    end
                end
            end
            PH_URI: begin
                if (is_ws(data_byte)) begin
                    nxt.phase    = PH_VER;
                    nxt.progress = '0;
                    nxt.mismatch = '0;
                end else if (cur.uri_count != URI_MAX) begin
                    nxt.uri_count = cur.uri_count + URI_W'(1);
                end
            end
            PH_VER: begin
                if (cur.progress < LEN_VER && data_byte != tok_ver(cur.progress))
                    mm_n[0] = 1'b1;
                nxt.mismatch = mm_n;
                nxt.progress = p_inc;
                if (p_inc >= LEN_VER) begin
                    if (mm_n != 2'b00) begin
                        hit = 1'b1;
                    end else begin
                        nxt.phase = PH_MINOR;
                    end
                end
            end
            PH_MINOR: begin
                hit = 1'b1;
                if (data_byte == "0") begin
                    st  = ST_OK;
                    ver = VER_1_0;
                end else if (data_byte == "1") begin
                    st  = ST_OK;
                    ver = VER_1_1;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase

        // byte count saturates at the buffer limit
        if (cur.pos < POS_W'(MAX_REQUEST_BYTES))
            pos_n = cur.pos + POS_W'(1);
        else
            pos_n = cur.pos;

        if (decided) begin
            nxt = cur;
            hit = 1'b0;
        end else begin
            nxt.pos = pos_n;
            if (!hit && (last || pos_n >= POS_W'(MAX_REQUEST_BYTES))) begin
                hit = 1'b1;
                st  = ST_INC;
            end
        end

        res.valid         = hit;
        res.status        = st;
        res.method        = nxt.method_code;
        res.version       = (st == ST_OK) ? ver : VER_NONE;
        res.method_length = (st == ST_OK) ? (nxt.uri_start - 3'd1) : 3'd0;
        res.uri_offset    = (st == ST_OK) ? nxt.uri_start : 3'd0;
        res.uri_length    = (st == ST_OK) ? nxt.uri_count : '0;

        if (hit)
            nxt.phase = PH_DONE;
        if (last)
            nxt = STATE_RESET;
    end

endmodule

`default_nettype wire

[rtl/http_request_line_parser_core.sv]
// ============================================================================
// HTTP request-line parser core
// Byte-serial recogniser for method, URI span and HTTP/1.x version.
// ============================================================================
//
//  channel  | ports                                  | word
//  ---------+----------------------------------------+---------------------------
//  s_ (in)  | s_valid s_ready s_data_byte s_last     | one request byte
//  m_ (out) | m_valid m_ready m_status m_method ...  | one verdict per request
//
//  One byte word per clock unless a held result stalls; the parser state
//  register is the only loop and closes through one byte's worth of compares.
//  Pipeline: two register stages (input register, then parser/result
//  register); a byte's verdict passes through both before m_valid rises.
//  Reset: aresetn low clears both stage valids and returns the parser to
//  the first method byte. No clearing pass.
//  Stalls: a held result only blocks a byte that is waiting behind it in
//  the input register; s_ready stays high while that register is free.
//
`default_nettype none

module http_request_line_parser_core
    import hrlp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_last,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_status,
    output logic [2:0]            m_method,
    output logic [1:0]            m_version,
    output logic [2:0]            m_method_length,
    output logic [2:0]            m_uri_offset,
    output logic [URI_W-1:0]      m_uri_length
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // parser state and result register
    hrlp_state_t  state_reg;
    hrlp_state_t  state_next;
    hrlp_result_t res_next;
    hrlp_result_t out_reg;

    logic         advance;
    logic         fire;

    // result register can take a new word when empty or being drained
    assign advance = !out_reg.valid || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    hrlp_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // valid is reset; the payload fields only load with a verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else begin
            if (advance) begin
                out_reg.valid <= fire && res_next.valid;
            end
            if (fire && res_next.valid) begin
                out_reg.status        <= res_next.status;
                out_reg.method        <= res_next.method;
                out_reg.version       <= res_next.version;
                out_reg.method_length <= res_next.method_length;
                out_reg.uri_offset    <= res_next.uri_offset;
                out_reg.uri_length    <= res_next.uri_length;
            end
        end
    end

    assign m_valid         = out_reg.valid;
    assign m_status        = out_reg.status;
    assign m_method        = out_reg.method;
    assign m_version       = out_reg.version;
    assign m_method_length = out_reg.method_length;
    assign m_uri_offset    = out_reg.uri_offset;
    assign m_uri_length    = out_reg.uri_length;

endmodule

`default_nettype wire

[rtl/hrlp_checker.sv]
// ============================================================================
// HTTP request-line parser: port checker
// Port-level checks on the result channel, bound to the core.
// ============================================================================
`default_nettype none

`include "http_request_line_parser_core_defines.svh"

module hrlp_checker
    import hrlp_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic [7:0]       s_data_byte,
    input wire logic             s_last,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [1:0]       m_status,
    input wire logic [2:0]       m_method,
    input wire logic [1:0]       m_version,
    input wire logic [2:0]       m_method_length,
    input wire logic [2:0]       m_uri_offset,
    input wire logic [URI_W-1:0] m_uri_length
);

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ s_last ^ (^s_data_byte);

    `HRLP_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result word after reset")

    `HRLP_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_uri_length), "stalled result word changed")

    `HRLP_ASSERT(a_ok_fields, m_valid && m_status == ST_OK |-> m_method != MTH_NONE && m_version != VER_NONE && m_uri_offset == m_method_length + 3'd1, "ok word with bad fields")

    `HRLP_ASSERT(a_fail_fields, m_valid && m_status != ST_OK |-> m_version == VER_NONE && m_uri_offset == 3'd0 && m_uri_length == '0, "failed word carries URI data")

    `HRLP_ASSERT(a_status_code, m_valid |-> m_status == ST_OK || m_status == ST_INC || m_status == ST_ERR, "undefined status code")

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_data_byte     (s_data_byte),
    .s_last          (s_last),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_method        (m_method),
    .m_version       (m_version),
    .m_method_length (m_method_length),
    .m_uri_offset    (m_uri_offset),
    .m_uri_length    (m_uri_length)
);

`default_nettype wire
